// ===== src/bls_pkg.sv =====
package bls_pkg;

    // fixed field widths
    localparam int SOC_BITS       = 10;
    localparam int VALUE_BITS     = 16;
    localparam int AVG_BITS       = 16;
    localparam int PV_POWER_BITS  = 16;
    localparam int EVENT_BITS     = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int PERIOD_BITS    = 9;

    // parameter defaults
    localparam int RING_DEPTH_DEF = 10;
    localparam int POWER_BITS_DEF = 16;

    // queue depths
    localparam int WORK_DEPTH   = 4;
    localparam int RESULT_DEPTH = 2;

    // behavior constants
    localparam logic [PERIOD_BITS-1:0] AVG_PERIOD = PERIOD_BITS'(360);
    localparam logic [VALUE_BITS-1:0]  SOC_MAX    = VALUE_BITS'(1000);
    localparam logic [AVG_BITS-1:0]    AVG_MAX    = '1;

    // register reset values
    localparam logic [SOC_BITS-1:0]      CFG_ENABLE_SOC_RST    = SOC_BITS'(900);
    localparam logic [SOC_BITS-1:0]      CFG_DISABLE_SOC_RST   = SOC_BITS'(300);
    localparam logic [SOC_BITS-1:0]      CFG_BOOT_SOC_RST      = SOC_BITS'(500);
    localparam logic [SOC_BITS-1:0]      CFG_HIGH_PV_SOC_RST   = SOC_BITS'(600);
    localparam int                       CFG_HIGH_PV_POWER_RST = 300;
    localparam logic [SOC_BITS-1:0]      CFG_MAX_STEP_RST      = SOC_BITS'(50);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ENABLE_SOC    = 3'd0,
        CFG_DISABLE_SOC   = 3'd1,
        CFG_BOOT_SOC      = 3'd2,
        CFG_HIGH_PV_SOC   = 3'd3,
        CFG_HIGH_PV_POWER = 3'd4,
        CFG_MAX_SOC_STEP  = 3'd5
    } t_cfg_index;

    typedef enum logic [1:0] {
        OP_SOC    = 2'd0,
        OP_POWER  = 2'd1,
        OP_TICK   = 2'd2,
        OP_MANUAL = 2'd3
    } t_op;

    typedef enum logic [EVENT_BITS-1:0] {
        EV_NONE        = 3'd0,
        EV_ON_SOC      = 3'd1,
        EV_ON_PV       = 3'd2,
        EV_ON_BOOT     = 3'd3,
        EV_OFF_LOW_SOC = 3'd4
    } t_event;

    typedef struct packed {
        logic [1:0]            operation;
        logic [VALUE_BITS-1:0] value;
    } t_item;

    typedef struct packed {
        logic                  load_on;
        logic                  auto_armed;
        logic [EVENT_BITS-1:0] switch_event;
        logic                  soc_discarded;
        logic [SOC_BITS-1:0]   soc_tenths;
        logic [AVG_BITS-1:0]   average_power;
    } t_result;

    // request after decode
    typedef struct packed {
        t_op                   kind;
        logic [VALUE_BITS-1:0] value;
        logic                  soc_ok;
        logic                  cmd_valid;
        logic                  cmd_on;
    } t_work;

endpackage

// ===== src/bls_fifo.sv =====
module bls_fifo
    import bls_pkg::*;
#(
    parameter type t_data = logic,
    parameter int  DEPTH  = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    t_data                r_slots [DEPTH];
    logic [PTR_BITS-1:0]  r_wr_ptr;
    logic [PTR_BITS-1:0]  r_rd_ptr;
    logic [CNT_BITS-1:0]  r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_slots[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/bls_front.sv =====
module bls_front
    import bls_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_work_push,
    output t_work o_work,
    input  logic  i_work_full
);

    logic  r_vld;
    t_work r_work;
    t_work n_work;
    logic  accept;
    logic  move;

    assign move        = r_vld && !i_work_full;
    assign o_full      = r_vld && i_work_full;
    assign accept      = i_push && !o_full;
    assign o_work_push = r_vld;
    assign o_work      = r_work;

    // decode the request
    always_comb begin
        n_work.kind      = t_op'(i_item.operation);
        n_work.value     = i_item.value;
        n_work.soc_ok    = (i_item.value <= SOC_MAX);
        n_work.cmd_valid = (i_item.value == VALUE_BITS'(0)) || (i_item.value == VALUE_BITS'(1));
        n_work.cmd_on    = (i_item.value == VALUE_BITS'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= accept || (r_vld && !move);
        end
        if (accept) begin
            r_work <= n_work;
        end
    end

endmodule

// ===== src/bls_div.sv =====
module bls_div
    import bls_pkg::*;
#(
    parameter int DIVIDEND_BITS = 20,
    parameter int DIVISOR       = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIVIDEND_BITS-1:0] i_dividend,
    output logic                     o_done,
    output logic [DIVIDEND_BITS-1:0] o_quotient
);

    // floor(x / d) = (x * ceil(2^k / d)) >> k with k = dividend bits + clog2(d)
    localparam int SHIFT      = DIVIDEND_BITS + $clog2(DIVISOR);
    localparam int RECIP_BITS = DIVIDEND_BITS + 2;
    localparam int PROD_BITS  = DIVIDEND_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic                 r_done;
    logic [PROD_BITS-1:0] r_prod;

    assign o_done     = r_done;
    assign o_quotient = DIVIDEND_BITS'(r_prod >> SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
        if (i_start) begin
            r_prod <= PROD_BITS'(i_dividend) * PROD_BITS'(RECIP);
        end
    end

endmodule

// ===== src/bls_back.sv =====
module bls_back
    import bls_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int POWER_BITS = POWER_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  t_work                     i_work,
    input  logic                      i_work_empty,
    output logic                      o_work_pop,
    output logic                      o_res_push,
    output t_result                   o_res,
    input  logic                      i_res_full
);

    localparam int SLOT_BITS = $clog2(RING_DEPTH);
    localparam int SUM_BITS  = POWER_BITS + SLOT_BITS;
    localparam int THR_BITS  = PV_POWER_BITS + SLOT_BITS;
    localparam int CMP_BITS  = (SUM_BITS > THR_BITS) ? SUM_BITS : THR_BITS;
    localparam logic [SLOT_BITS-1:0]   LAST_SLOT  = SLOT_BITS'(RING_DEPTH - 1);
    localparam logic [SLOT_BITS-1:0]   FIRST_NEXT = SLOT_BITS'(1);
    localparam logic [PERIOD_BITS-1:0] LAST_TICK  = AVG_PERIOD - 1'b1;
    localparam logic [THR_BITS-1:0]    THR_RST    = THR_BITS'(CFG_HIGH_PV_POWER_RST * RING_DEPTH);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_SEND
    } t_state;

    function automatic logic [AVG_BITS-1:0] f_sat(input logic [SUM_BITS-1:0] q);
        return (q > SUM_BITS'(AVG_MAX)) ? AVG_MAX : AVG_BITS'(q);
    endfunction

    t_state                  r_state,       n_state;
    logic [SOC_BITS-1:0]     r_enable_soc;
    logic [SOC_BITS-1:0]     r_disable_soc;
    logic [SOC_BITS-1:0]     r_boot_soc;
    logic [SOC_BITS-1:0]     r_pv_soc;
    logic [THR_BITS-1:0]     r_pv_thresh;
    logic [SOC_BITS-1:0]     r_max_step;
    logic [SOC_BITS-1:0]     r_soc,         n_soc;
    logic [POWER_BITS-1:0]   r_latest,      n_latest;
    logic [POWER_BITS-1:0]   r_fill,        n_fill;
    logic [SLOT_BITS-1:0]    r_slot,        n_slot;
    logic [SUM_BITS-1:0]     r_sum,         n_sum;
    logic [PERIOD_BITS-1:0]  r_period,      n_period;
    logic                    r_boot,        n_boot;
    logic                    r_auto,        n_auto;
    logic                    r_load,        n_load;
    logic [AVG_BITS-1:0]     r_avg,         n_avg;
    t_result                 r_held,        n_held;
    logic [RING_DEPTH-1:0]   r_ring_vld;
    logic                    r_rd_vld;
    logic [POWER_BITS-1:0]   r_rd;
    logic [POWER_BITS-1:0]   r_ring [RING_DEPTH];

    logic                    go;
    logic                    snap;
    logic                    ring_we;
    logic                    discarded;
    logic                    pend_vld;
    logic                    pend_on;
    logic                    pv_high;
    t_event                  ev;
    t_result                 res;
    logic [SOC_BITS-1:0]     val_soc;
    logic [SOC_BITS-1:0]     diff;
    logic [POWER_BITS-1:0]   old_power;
    logic                    div_done;
    logic [SUM_BITS-1:0]     div_q;

    assign val_soc   = i_work.value[SOC_BITS-1:0];
    assign diff      = (val_soc > r_soc) ? (val_soc - r_soc) : (r_soc - val_soc);
    assign old_power = r_rd_vld ? r_rd : r_fill;
    assign go        = (r_state == ST_RUN) && !i_work_empty && !i_res_full;
    assign o_work_pop = go;

    always_comb begin
        n_state   = r_state;
        n_soc     = r_soc;
        n_latest  = r_latest;
        n_fill    = r_fill;
        n_slot    = r_slot;
        n_sum     = r_sum;
        n_period  = r_period;
        n_boot    = r_boot;
        n_auto    = r_auto;
        n_load    = r_load;
        n_avg     = r_avg;
        n_held    = r_held;
        snap      = 1'b0;
        ring_we   = 1'b0;
        discarded = 1'b0;
        pend_vld  = 1'b0;
        pend_on   = 1'b0;
        ev        = EV_NONE;
        pv_high   = 1'b0;
        o_res_push = 1'b0;

        // request action
        if (go) begin
            unique case (i_work.kind)
                OP_SOC: begin
                    if (i_work.soc_ok) begin
                        if (r_boot || (diff <= r_max_step)) begin
                            n_soc = val_soc;
                        end else begin
                            discarded = 1'b1;
                        end
                    end
                end
                OP_POWER: begin
                    n_latest = POWER_BITS'(i_work.value);
                end
                OP_TICK: begin
                    if (r_boot) begin
                        // whole ring takes the latest power at once
                        n_fill   = r_latest;
                        n_sum    = SUM_BITS'(r_latest) * SUM_BITS'(RING_DEPTH);
                        n_slot   = FIRST_NEXT;
                        n_period = '0;
                        n_boot   = 1'b0;
                        n_avg    = f_sat(SUM_BITS'(r_latest));
                    end else if (r_period == LAST_TICK) begin
                        n_sum    = r_sum - SUM_BITS'(old_power) + SUM_BITS'(r_latest);
                        ring_we  = 1'b1;
                        n_slot   = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                        n_period = '0;
                        snap     = 1'b1;
                    end else begin
                        n_period = r_period + 1'b1;
                    end
                end
                OP_MANUAL: begin
                    if (i_work.cmd_valid) begin
                        pend_vld = 1'b1;
                        pend_on  = i_work.cmd_on;
                    end
                end
                default: ;
            endcase

            // load controller, floor(sum/depth) >= p is sum >= p*depth
            pv_high = (CMP_BITS'(n_sum) >= CMP_BITS'(r_pv_thresh));
            if (!r_auto) begin
                if (n_soc >= r_enable_soc) begin
                    ev = EV_ON_SOC;
                end else if (pv_high && (n_soc >= r_pv_soc)) begin
                    ev = EV_ON_PV;
                end else if (n_boot && (n_soc >= r_boot_soc)) begin
                    ev = EV_ON_BOOT;
                end
                if (ev != EV_NONE) begin
                    pend_vld = 1'b1;
                    pend_on  = 1'b1;
                    n_auto   = 1'b1;
                end
            end
            if (r_load && (n_soc <= r_disable_soc)) begin
                pend_vld = 1'b1;
                pend_on  = 1'b0;
                n_auto   = 1'b0;
                ev       = EV_OFF_LOW_SOC;
            end
            if (pend_vld) begin
                n_load = pend_on;
            end
        end

        res.load_on       = n_load;
        res.auto_armed    = n_auto;
        res.switch_event  = ev;
        res.soc_discarded = discarded;
        res.soc_tenths    = n_soc;
        res.average_power = n_avg;

        unique case (r_state)
            ST_RUN: begin
                if (snap) begin
                    n_held  = res;
                    n_state = ST_DIV;
                end else begin
                    o_res_push = go;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_avg                = f_sat(div_q);
                    n_held.average_power = f_sat(div_q);
                    n_state              = ST_SEND;
                end
            end
            ST_SEND: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    assign o_res = (r_state == ST_SEND) ? r_held : res;

    bls_div #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR       (RING_DEPTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (snap),
        .i_dividend (n_sum),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // ring memory, read address follows the next slot
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_slot] <= r_latest;
        end
        r_rd <= r_ring[n_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_RUN;
            r_enable_soc  <= CFG_ENABLE_SOC_RST;
            r_disable_soc <= CFG_DISABLE_SOC_RST;
            r_boot_soc    <= CFG_BOOT_SOC_RST;
            r_pv_soc      <= CFG_HIGH_PV_SOC_RST;
            r_pv_thresh   <= THR_RST;
            r_max_step    <= CFG_MAX_STEP_RST;
            r_soc         <= '0;
            r_latest      <= '0;
            r_fill        <= '0;
            r_slot        <= '0;
            r_sum         <= '0;
            r_period      <= '0;
            r_boot        <= 1'b1;
            r_auto        <= 1'b0;
            r_load        <= 1'b0;
            r_avg         <= '0;
            r_ring_vld    <= '0;
            r_rd_vld      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_soc    <= n_soc;
            r_latest <= n_latest;
            r_fill   <= n_fill;
            r_slot   <= n_slot;
            r_sum    <= n_sum;
            r_period <= n_period;
            r_boot   <= n_boot;
            r_auto   <= n_auto;
            r_load   <= n_load;
            r_avg    <= n_avg;
            r_rd_vld <= r_ring_vld[n_slot];
            if (ring_we) begin
                r_ring_vld[r_slot] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_ENABLE_SOC:    r_enable_soc  <= i_cfg_data[SOC_BITS-1:0];
                    CFG_DISABLE_SOC:   r_disable_soc <= i_cfg_data[SOC_BITS-1:0];
                    CFG_BOOT_SOC:      r_boot_soc    <= i_cfg_data[SOC_BITS-1:0];
                    CFG_HIGH_PV_SOC:   r_pv_soc      <= i_cfg_data[SOC_BITS-1:0];
                    CFG_HIGH_PV_POWER: r_pv_thresh   <= THR_BITS'(i_cfg_data) *
                                                        THR_BITS'(RING_DEPTH);
                    CFG_MAX_SOC_STEP:  r_max_step    <= i_cfg_data[SOC_BITS-1:0];
                    default: ;
                endcase
            end
        end
        r_held <= n_held;
    end

endmodule

// ===== src/battery_load_switch_supervisor_unit.sv =====
// path: a request is registered in the front end, passes the work queue, the back end
//   and the result queue; one request per cycle while no queue is full; a tick that
//   stores a pv snapshot (every 360th tick after the first) holds the back end in its
//   divide and send states while a reciprocal multiply forms the new average
// reset: synchronous active-low; queues empty, registers at defaults, boot window open;
//   the pv ring is not cleared, its slots are marked unwritten and read as the boot fill
module battery_load_switch_supervisor_unit
    import bls_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int POWER_BITS = POWER_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request side
    input  logic                      push,
    output logic                      full,
    input  t_item                     i_item,
    // result side
    output logic                      empty,
    input  logic                      pop,
    output t_result                   o_result,
    // register writes
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    // front end to work queue
    logic    front_push;
    t_work   front_work;
    logic    work_full;

    // work queue to back end
    t_work   work_head;
    logic    work_empty;
    logic    work_pop;

    // back end to result queue
    logic    res_push;
    t_result res_data;
    logic    res_full;

    // front end registers and decodes each request
    bls_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_work_push (front_push),
        .o_work      (front_work),
        .i_work_full (work_full)
    );

    // decouples decode from execution
    bls_fifo #(
        .t_data (t_work),
        .DEPTH  (WORK_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_work),
        .o_full  (work_full),
        .i_pop   (work_pop),
        .o_data  (work_head),
        .o_empty (work_empty)
    );

    // soc filter, pv ring, load controller and config registers
    bls_back #(
        .RING_DEPTH (RING_DEPTH),
        .POWER_BITS (POWER_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_work       (work_head),
        .i_work_empty (work_empty),
        .o_work_pop   (work_pop),
        .o_res_push   (res_push),
        .o_res        (res_data),
        .i_res_full   (res_full)
    );

    // finished results wait here so the back end keeps going
    bls_fifo #(
        .t_data (t_result),
        .DEPTH  (RESULT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

// ===== src/bls_port_check.sv =====
module bls_port_check
    import bls_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    push,
    input logic    full,
    input t_item   i_item,
    input logic    empty,
    input logic    pop,
    input t_result o_result
);

    logic [7:0] r_open;
    logic       took_in;
    logic       took_out;

    assign took_in  = push && !full;
    assign took_out = pop && !empty;

    // requests taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + 8'(took_in) - 8'(took_out);
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_open != 8'd0))
        else $error("result without a pending request");

    a_on_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && ((o_result.switch_event == EV_ON_SOC) ||
                    (o_result.switch_event == EV_ON_PV) ||
                    (o_result.switch_event == EV_ON_BOOT)))
        |-> (o_result.load_on && o_result.auto_armed))
        else $error("automatic enable without load on and armed");

    a_off_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.switch_event == EV_OFF_LOW_SOC))
        |-> (!o_result.load_on && !o_result.auto_armed))
        else $error("low soc disable left load or arm set");

    a_soc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (VALUE_BITS'(o_result.soc_tenths) <= SOC_MAX))
        else $error("stored soc out of range");

endmodule

bind battery_load_switch_supervisor_unit bls_port_check u_port_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .i_item   (i_item),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bls_pkg::*;

    // cycles with no request and no result taken before the run is declared hung
    localparam int QUIET_LIMIT  = 2000;
    // cycles left for stray results once everything expected has come back
    localparam int FINAL_SETTLE = 40;
    // ticks needed so that at least one scheduled pv snapshot lands after the boot fill
    localparam int TICK_TARGET  = 380;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      push        = 1'b0;
    logic                      full;
    t_item                     i_item      = '0;
    logic                      empty;
    logic                      pop         = 1'b0;
    t_result                   o_result;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data  = '0;

    battery_load_switch_supervisor_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow copy of the threshold registers, reset values from the package
    // ------------------------------------------------------------------
    logic [SOC_BITS-1:0]      cfg_enable   = CFG_ENABLE_SOC_RST;
    logic [SOC_BITS-1:0]      cfg_disable  = CFG_DISABLE_SOC_RST;
    logic [SOC_BITS-1:0]      cfg_boot     = CFG_BOOT_SOC_RST;
    logic [SOC_BITS-1:0]      cfg_pv_soc   = CFG_HIGH_PV_SOC_RST;
    logic [PV_POWER_BITS-1:0] cfg_pv_power = PV_POWER_BITS'(CFG_HIGH_PV_POWER_RST);
    logic [SOC_BITS-1:0]      cfg_step     = CFG_MAX_STEP_RST;

    // ------------------------------------------------------------------
    // supervisor state as the switch status predictor sees it
    // ------------------------------------------------------------------
    logic [SOC_BITS-1:0]       soc_now      = '0;
    logic [POWER_BITS_DEF-1:0] power_latest = '0;
    logic [POWER_BITS_DEF-1:0] power_slots [RING_DEPTH_DEF];
    int                        slot_ptr     = 0;
    int unsigned               power_total  = 0;
    int                        tick_count   = 0;
    bit                        boot_open    = 1'b1;
    bit                        armed        = 1'b0;
    bit                        load         = 1'b0;

    t_item   request_queue [$];   // requests waiting for the driver
    t_result status_queue [$];    // predicted status, oldest first
    int      ticks_queued    = 0;
    int      mismatch_count  = 0;

    // replace the oldest pv snapshot with the latest sample, keep the sum in step
    task automatic store_power_snapshot();
        power_total = power_total - power_slots[slot_ptr] + power_latest;
        power_slots[slot_ptr] = power_latest;
        slot_ptr = (slot_ptr + 1 == RING_DEPTH_DEF) ? 0 : slot_ptr + 1;
    endtask

    // switch status after one accepted request; advances the predicted state
    task automatic compute_switch_status(input t_item req, output t_result res);
        int unsigned diff;
        int unsigned avg;
        bit          cmd_valid;
        bit          cmd_on;
        bit          dropped;
        t_event      ev;
        cmd_valid = 1'b0;
        cmd_on    = 1'b0;
        dropped   = 1'b0;
        ev        = EV_NONE;

        // the request's own action
        case (req.operation)
            OP_SOC: begin
                // out-of-range samples vanish without a flag
                if (req.value <= SOC_MAX) begin
                    diff = (req.value > soc_now) ? req.value - soc_now : soc_now - req.value;
                    // no plausibility check while the boot window is open
                    if (boot_open || diff <= cfg_step)
                        soc_now = req.value[SOC_BITS-1:0];
                    else
                        dropped = 1'b1;
                end
            end
            OP_POWER: begin
                power_latest = req.value[POWER_BITS_DEF-1:0];
            end
            OP_TICK: begin
                if (boot_open) begin
                    // first tick seeds the whole ring and closes the boot window
                    for (int k = 0; k < RING_DEPTH_DEF; k++)
                        power_slots[k] = power_latest;
                    power_total = power_latest * RING_DEPTH_DEF;
                    store_power_snapshot();
                    tick_count = 0;
                    boot_open  = 1'b0;
                end else begin
                    tick_count++;
                    if (tick_count >= AVG_PERIOD) begin
                        store_power_snapshot();
                        tick_count = 0;
                    end
                end
            end
            OP_MANUAL: begin
                // anything but 0 or 1 is ignored
                if (req.value == 0) begin
                    cmd_valid = 1'b1;
                    cmd_on    = 1'b0;
                end else if (req.value == 1) begin
                    cmd_valid = 1'b1;
                    cmd_on    = 1'b1;
                end
            end
        endcase

        avg = power_total / RING_DEPTH_DEF;

        // one automatic enable at most, priority soc, then high pv, then boot
        if (!armed) begin
            if (soc_now >= cfg_enable)
                ev = EV_ON_SOC;
            else if (avg >= cfg_pv_power && soc_now >= cfg_pv_soc)
                ev = EV_ON_PV;
            else if (boot_open && soc_now >= cfg_boot)
                ev = EV_ON_BOOT;
            if (ev != EV_NONE) begin
                cmd_valid = 1'b1;
                cmd_on    = 1'b1;
                armed     = 1'b1;
            end
        end

        // low soc cuts an active load and overrides any enable in the same request
        if (load && soc_now <= cfg_disable) begin
            cmd_valid = 1'b1;
            cmd_on    = 1'b0;
            armed     = 1'b0;
            ev        = EV_OFF_LOW_SOC;
        end
        if (cmd_valid)
            load = cmd_on;

        res.load_on       = load;
        res.auto_armed    = armed;
        res.switch_event  = ev;
        res.soc_discarded = dropped;
        res.soc_tenths    = soc_now;
        res.average_power = (avg > AVG_MAX) ? AVG_MAX : AVG_BITS'(avg);
    endtask

    function automatic void queue_request(input t_op op, input logic [VALUE_BITS-1:0] v);
        t_item req;
        req.operation = op;
        req.value     = v;
        request_queue.push_back(req);
        if (op == OP_TICK)
            ticks_queued++;
    endfunction

    // write all six thresholds back to back; only called with the unit idle
    task automatic write_config(input logic [CFG_DATA_BITS-1:0] en, input logic [CFG_DATA_BITS-1:0] dis,
                                input logic [CFG_DATA_BITS-1:0] boot, input logic [CFG_DATA_BITS-1:0] pvsoc,
                                input logic [CFG_DATA_BITS-1:0] pvpow, input logic [CFG_DATA_BITS-1:0] step);
        t_cfg_index               idx [6];
        logic [CFG_DATA_BITS-1:0] val [6];
        idx = '{CFG_ENABLE_SOC, CFG_DISABLE_SOC, CFG_BOOT_SOC,
                CFG_HIGH_PV_SOC, CFG_HIGH_PV_POWER, CFG_MAX_SOC_STEP};
        val = '{en, dis, boot, pvsoc, pvpow, step};
        for (int k = 0; k < 6; k++) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        // nothing is in flight, so the shadow can follow at once
        cfg_enable   = en[SOC_BITS-1:0];
        cfg_disable  = dis[SOC_BITS-1:0];
        cfg_boot     = boot[SOC_BITS-1:0];
        cfg_pv_soc   = pvsoc[SOC_BITS-1:0];
        cfg_pv_power = pvpow[PV_POWER_BITS-1:0];
        cfg_step     = step[SOC_BITS-1:0];
    endtask

    // block until every queued request went in and every status came back
    task automatic wait_until_idle();
        @(negedge i_clk);
        while (request_queue.size() != 0 || push || status_queue.size() != 0)
            @(negedge i_clk);
    endtask

    // a run of ticks, then mixed random traffic; soc samples mostly walk within the
    // step limit so they get past the plausibility check, the rest are jumps and junk
    task automatic queue_random_phase(input int mixed, input int tick_run);
        int pick;
        int cand;
        int gen_soc;
        int gen_dir;
        int dist_abs;
        logic [VALUE_BITS-1:0] manual_val;
        gen_soc = soc_now;
        gen_dir = 1;
        for (int n = 0; n < tick_run; n++)
            queue_request(OP_TICK, VALUE_BITS'($urandom));
        for (int n = 0; n < mixed; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                queue_request(OP_TICK, VALUE_BITS'($urandom));
            end else if (pick < 65) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // plausible drift, turning at the ends of the range
                    cand = gen_soc + gen_dir * int'($urandom_range(0, cfg_step));
                    if ($urandom_range(0, 19) == 0)
                        gen_dir = -gen_dir;
                end else if (pick < 80) begin
                    cand = $urandom_range(0, SOC_MAX);
                end else if (pick < 85) begin
                    case ($urandom_range(0, 3))
                        0: cand = cfg_enable;
                        1: cand = cfg_disable;
                        2: cand = cfg_pv_soc;
                        default: cand = cfg_boot;
                    endcase
                end else if (pick < 95) begin
                    cand = $urandom_range(SOC_MAX + 1, 16'hFFFF);
                end else begin
                    // one tenth past the step limit
                    cand = gen_soc + gen_dir * (int'(cfg_step) + 1);
                end
                if (pick < 70 || pick >= 95) begin
                    if (cand <= 0) begin
                        cand = 0;
                        gen_dir = 1;
                    end else if (cand >= SOC_MAX) begin
                        cand = SOC_MAX;
                        gen_dir = -1;
                    end
                end
                dist_abs = (cand > gen_soc) ? cand - gen_soc : gen_soc - cand;
                if (cand <= SOC_MAX && dist_abs <= cfg_step)
                    gen_soc = cand;
                queue_request(OP_SOC, VALUE_BITS'(cand));
            end else if (pick < 80) begin
                if ($urandom_range(0, 3) == 0)
                    queue_request(OP_POWER, VALUE_BITS'($urandom));
                else
                    queue_request(OP_POWER, VALUE_BITS'($urandom_range(0, 1000)));
            end else begin
                case ($urandom_range(0, 9))
                    0: manual_val = VALUE_BITS'($urandom);
                    1, 2, 3, 4: manual_val = '0;
                    default: manual_val = VALUE_BITS'(1);
                endcase
                queue_request(OP_MANUAL, manual_val);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of requests with random gaps between them
    // ------------------------------------------------------------------
    int      burst_left = 0;
    int      gap_left   = 0;
    t_result predicted;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push       <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            // request taken at this edge: predict its status now
            if (push && !full) begin
                compute_switch_status(i_item, predicted);
                status_queue.push_back(predicted);
            end
            // a request held off by full stays on the port untouched
            if (!(push && full)) begin
                if (burst_left == 0) begin
                    if ($urandom_range(0, 4) == 0) begin
                        // long back-to-back stretch
                        burst_left = $urandom_range(40, 150);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 7);
                    end
                end
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    i_item <= request_queue.pop_front();
                    push   <= 1'b1;
                    burst_left--;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: pops with its own stall pattern, checks against the prediction
    // ------------------------------------------------------------------
    int      stall_mode = 0;
    int      stall_left = 0;
    t_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (status_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: status with no request behind it: %p", $realtime, o_result);
                end else begin
                    want = status_queue.pop_front();
                    if (o_result.load_on !== want.load_on
                            || o_result.auto_armed !== want.auto_armed
                            || o_result.switch_event !== want.switch_event
                            || o_result.soc_discarded !== want.soc_discarded
                            || o_result.soc_tenths !== want.soc_tenths
                            || o_result.average_power !== want.average_power) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: status mismatch load %0d/%0d armed %0d/%0d ",
                                      "event %0d/%0d discarded %0d/%0d soc %0d/%0d ",
                                      "avg %0d/%0d (expected/actual)"}, $realtime,
                                     want.load_on, o_result.load_on,
                                     want.auto_armed, o_result.auto_armed,
                                     want.switch_event, o_result.switch_event,
                                     want.soc_discarded, o_result.soc_discarded,
                                     want.soc_tenths, o_result.soc_tenths,
                                     want.average_power, o_result.average_power);
                    end
                end
            end
            // stall modes: always ready, coin flip, mostly stalled, hard stall
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = (stall_mode == 3) ? $urandom_range(1, 25) : $urandom_range(1, 60);
            end
            stall_left--;
            case (stall_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= ($urandom_range(0, 7) == 0);
                default: pop <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // watchdog on handshake progress
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset, directed cases, then random phases at several settings
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds, boot window still open
        queue_request(OP_MANUAL, VALUE_BITS'(2));       // illegal manual value, ignored
        queue_request(OP_SOC, 16'hFFFF);                // out of range, silent
        queue_request(OP_SOC, VALUE_BITS'(SOC_MAX + 1));
        queue_request(OP_SOC, VALUE_BITS'(550));        // big jump ok in boot, boot enable
        queue_request(OP_MANUAL, '0);                   // manual off keeps the arm flag
        queue_request(OP_MANUAL, VALUE_BITS'(1));
        queue_request(OP_SOC, VALUE_BITS'(200));        // low soc cuts the load
        queue_request(OP_POWER, 16'hFFFF);
        queue_request(OP_POWER, '0);
        queue_request(OP_POWER, VALUE_BITS'(400));
        queue_request(OP_MANUAL, 16'hFFFF);
        queue_request(OP_SOC, VALUE_BITS'(SOC_MAX));    // enable on soc
        queue_request(OP_TICK, '0);                     // first tick seeds the ring
        queue_request(OP_SOC, VALUE_BITS'(949));        // one past the step limit
        queue_request(OP_SOC, VALUE_BITS'(950));        // exactly at the step limit
        queue_request(OP_SOC, '0);
        wait_until_idle();

        // enable and disable hitting the same request
        write_config(300, 300, 500, 1000, 16'hFFFF, 1000);
        queue_request(OP_SOC, VALUE_BITS'(250));
        queue_request(OP_MANUAL, VALUE_BITS'(1));
        queue_request(OP_SOC, VALUE_BITS'(300));
        wait_until_idle();

        // high pv enable
        write_config(1000, 0, 500, 500, 400, 1000);
        queue_request(OP_SOC, VALUE_BITS'(600));
        queue_request(OP_SOC, VALUE_BITS'(SOC_MAX));
        queue_request(OP_MANUAL, '0);
        wait_until_idle();

        // random phases; the sender waits for a full drain between them
        write_config(900, 300, 500, 600, 300, 50);
        queue_random_phase(46, 60);
        wait_until_idle();

        write_config(0, 0, 0, 0, 0, 0);
        queue_random_phase(46, 60);
        wait_until_idle();

        write_config(1000, 1000, 1000, 1000, 16'hFFFF, 1000);
        queue_random_phase(46, 60);
        wait_until_idle();

        write_config(CFG_DATA_BITS'($urandom_range(0, 1000)),
                     CFG_DATA_BITS'($urandom_range(0, 1000)),
                     CFG_DATA_BITS'($urandom_range(0, 1000)),
                     CFG_DATA_BITS'($urandom_range(0, 1000)),
                     CFG_DATA_BITS'($urandom_range(0, 800)),
                     CFG_DATA_BITS'($urandom_range(0, 1000)));
        queue_random_phase(46, 60);
        wait_until_idle();

        write_config(700, 250, 450, 550, 350, 80);
        queue_random_phase(46, 60);
        // make sure the scheduled snapshot and the divider get exercised
        while (ticks_queued < TICK_TARGET)
            queue_request(OP_TICK, VALUE_BITS'($urandom));
        wait_until_idle();

        // catch anything that shows up late
        repeat (FINAL_SETTLE) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bls_pkg.sv
src/bls_fifo.sv
src/bls_front.sv
src/bls_div.sv
src/bls_back.sv
src/battery_load_switch_supervisor_unit.sv
src/bls_port_check.sv
test/tb.sv
